// File: sv/rtb_pkg.sv
// Shared types and constants for the repeating timer bank.
// Used by the channel interfaces, the timer cell and the top level.
`default_nettype none

package rtb_pkg;

   // Result limit per tick and field widths
   localparam int MaxResults    = 8;
   localparam int FireW         = 6;
   localparam int FireCntW      = $clog2(MaxResults + 1);
   localparam int SlotW         = $clog2(MaxResults);
   localparam int IdW           = 8;
   localparam int WordW         = 32;
   localparam int TimersDefault = 8;

   typedef enum logic [1:0] {
      OP_CONFIG = 2'd0,
      OP_RUN    = 2'd1,
      OP_STOP   = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   typedef enum logic {
      KIND_FIRE  = 1'b0,
      KIND_ERROR = 1'b1
   } kind_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic              valid;
      opcode_type        opcode;
      logic [IdW-1:0]    timer_id;
      logic [WordW-1:0]  value;
      logic [WordW-1:0]  now;
   } cmd_type;

   // Scan token handed from cell to cell, collecting fired indices
   typedef struct packed {
      logic                                valid;
      logic [WordW-1:0]                    now;
      logic [FireCntW-1:0]                 fires;
      logic [MaxResults-1:0][FireW-1:0]    list;
   } token_type;

endpackage

`default_nettype wire

// File: sv/rtb_chan_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on rtb_pkg for field widths.
`default_nettype none

interface rtb_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [rtb_pkg::IdW-1:0]     timer_id;
   logic [rtb_pkg::WordW-1:0]   value;
   logic [rtb_pkg::WordW-1:0]   now;

   modport source (output valid, opcode, timer_id, value, now, input ready);
   modport sink   (input valid, opcode, timer_id, value, now, output ready);
endinterface

interface rtb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [rtb_pkg::FireW-1:0]   fired_timer;
   logic                        last;

   modport source (output valid, kind, fired_timer, last, input ready);
   modport sink   (input valid, kind, fired_timer, last, output ready);
endinterface

`default_nettype wire

// File: sv/rtb_cell.sv
// One timer of the bank: interval, remaining count and deadline, plus one
// stage of the scan token chain. Depends on rtb_pkg.
`default_nettype none

module rtb_cell #(
   parameter int CellIndex = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  rtb_pkg::cmd_type        cmd,
   input  rtb_pkg::token_type      up_tok,
   output rtb_pkg::token_type      down_tok
);

   logic [rtb_pkg::WordW-1:0] interval_ff, interval_in;
   logic [rtb_pkg::WordW-1:0] count_ff,    count_in;
   logic [rtb_pkg::WordW-1:0] deadline_ff, deadline_in;
   rtb_pkg::token_type        tok_ff,      tok_in;

   logic                      sel;
   logic                      due;
   logic [rtb_pkg::WordW-1:0] count_dec;

   // Fire on a passing token, or apply an addressed command
   always_comb begin
      sel       = cmd.valid && (cmd.timer_id == rtb_pkg::IdW'(CellIndex));
      count_dec = count_ff - 1'b1;
      due       = up_tok.valid && (deadline_ff != '0) && (deadline_ff <= up_tok.now)
                  && (up_tok.fires < rtb_pkg::FireCntW'(rtb_pkg::MaxResults));

      interval_in = interval_ff;
      count_in    = count_ff;
      deadline_in = deadline_ff;
      tok_in      = up_tok;

      if (due) begin
         count_in    = count_dec;
         deadline_in = (count_dec != '0) ? deadline_ff + interval_ff : '0;
         tok_in.list[up_tok.fires[rtb_pkg::SlotW-1:0]] = rtb_pkg::FireW'(CellIndex);
         tok_in.fires = up_tok.fires + 1'b1;
      end else if (sel) begin
         unique case (cmd.opcode)
            rtb_pkg::OP_CONFIG: begin
               interval_in = cmd.value;
               count_in    = '0;
               deadline_in = '0;
            end
            rtb_pkg::OP_RUN: begin
               count_in    = cmd.value;
               deadline_in = cmd.now + interval_ff;
            end
            rtb_pkg::OP_STOP: begin
               deadline_in = '0;
            end
            rtb_pkg::OP_TICK: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Hold timer state, advance the token
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         count_ff    <= '0;
         deadline_ff <= '0;
         tok_ff      <= '0;
      end else begin
         interval_ff <= interval_in;
         count_ff    <= count_in;
         deadline_ff <= deadline_in;
         tok_ff      <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

`default_nettype wire

// File: sv/repeating_timer_bank_unit.sv
// Repeating timer bank: a row of timer cells swept by a scan token.
// Depends on rtb_pkg, rtb_chan_if and rtb_cell.
//
// Use: command items arrive on req_chan (opcode, timer_id, value, now).
// Config, run and stop with a valid id update the addressed cell through the
// registered command and give no result; the next item may follow at once.
// With an id >= TIMERS they give one error result (kind 1, index 0, last 1).
// A tick launches a token down the cell row, one cell per cycle; each due
// timer writes its index into the token, at most eight per tick. The
// collected indices then leave on rsp_chan at one per cycle while rsp_chan is
// ready, in index order, with last set on the final one. A tick with
// nothing due gives no result.
// A command leaves req_chan ready for the next item; an error or a tick keeps
// req_chan.ready low until its scan, if any, and drain are done; the cell row
// length sets the scan time. The next item is taken once the final result has
// moved into the output register, even while that result waits to be taken.
// When rsp_chan stalls, the output register holds its result and the drain
// waits; req_chan.ready stays low until the drain is done.
// Reset (synchronous) stops every timer and clears intervals and counts.
`default_nettype none

module repeating_timer_bank_unit #(
   parameter int TIMERS = rtb_pkg::TimersDefault
) (
   input wire logic   clock,
   input wire logic   reset,
   rtb_req_if.sink    req_chan,
   rtb_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type                                         state_ff, state_in;
   rtb_pkg::cmd_type                                  cmd_ff, cmd_in;
   rtb_pkg::token_type                                tok0_ff, tok0_in;
   logic [rtb_pkg::MaxResults-1:0][rtb_pkg::FireW-1:0] drain_list_ff, drain_list_in;
   logic [rtb_pkg::FireCntW-1:0]                      drain_cnt_ff, drain_cnt_in;
   logic [rtb_pkg::FireCntW-1:0]                      drain_ptr_ff, drain_ptr_in;
   rtb_pkg::kind_type                                 drain_kind_ff, drain_kind_in;
   logic                                              rsp_valid_ff, rsp_valid_in;
   rtb_pkg::kind_type                                 rsp_kind_ff, rsp_kind_in;
   logic [rtb_pkg::FireW-1:0]                         rsp_idx_ff, rsp_idx_in;
   logic                                              rsp_last_ff, rsp_last_in;

   rtb_pkg::token_type  tok_chain [TIMERS+1];
   rtb_pkg::opcode_type req_op;
   logic                accept;
   logic                id_bad;
   logic                out_free;
   logic                drain_last;

   // Cell row
   assign tok_chain[0] = tok0_ff;

   for (genvar g = 0; g < TIMERS; g++) begin : g_cell
      rtb_cell #(
         .CellIndex (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .up_tok   (tok_chain[g]),
         .down_tok (tok_chain[g+1])
      );
   end

   // Handshake decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_op         = rtb_pkg::opcode_type'(req_chan.opcode);
   assign id_bad         = req_chan.timer_id >= rtb_pkg::IdW'(TIMERS);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign drain_last     = rtb_pkg::FireCntW'(drain_ptr_ff + 1'b1) == drain_cnt_ff;

   // Sequence commands, scans and the result drain
   always_comb begin
      state_in      = state_ff;
      cmd_in        = '0;
      tok0_in       = '0;
      drain_list_in = drain_list_ff;
      drain_cnt_in  = drain_cnt_ff;
      drain_ptr_in  = drain_ptr_ff;
      drain_kind_in = drain_kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == rtb_pkg::OP_TICK) begin
                  tok0_in.valid = 1'b1;
                  tok0_in.now   = req_chan.now;
                  state_in      = ST_SCAN;
               end else if (id_bad) begin
                  drain_list_in = '0;
                  drain_cnt_in  = rtb_pkg::FireCntW'(1);
                  drain_ptr_in  = '0;
                  drain_kind_in = rtb_pkg::KIND_ERROR;
                  state_in      = ST_DRAIN;
               end else begin
                  cmd_in.valid    = 1'b1;
                  cmd_in.opcode   = req_op;
                  cmd_in.timer_id = req_chan.timer_id;
                  cmd_in.value    = req_chan.value;
                  cmd_in.now      = req_chan.now;
               end
            end
         end
         ST_SCAN: begin
            if (tok_chain[TIMERS].valid) begin
               drain_list_in = tok_chain[TIMERS].list;
               drain_cnt_in  = tok_chain[TIMERS].fires;
               drain_ptr_in  = '0;
               drain_kind_in = rtb_pkg::KIND_FIRE;
               state_in      = (tok_chain[TIMERS].fires == '0) ? ST_IDLE : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = drain_kind_ff;
               rsp_idx_in   = drain_list_ff[drain_ptr_ff[rtb_pkg::SlotW-1:0]];
               rsp_last_in  = drain_last;
               drain_ptr_in = drain_ptr_ff + 1'b1;
               if (drain_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the output register
   always_ff @(posedge clock) begin
      drain_list_ff <= drain_list_in;
      drain_cnt_ff  <= drain_cnt_in;
      drain_ptr_ff  <= drain_ptr_in;
      drain_kind_ff <= drain_kind_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= '0;
         tok0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         tok0_ff      <= tok0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.fired_timer = rsp_idx_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // The token leaves the row only while a scan is in progress
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_chain[TIMERS].valid |-> state_ff == ST_SCAN)
      else $error("scan token left the cell row outside a scan");

   // The drain pointer stays inside the collected list
   a_drain_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> drain_ptr_ff < drain_cnt_ff
                               && drain_cnt_ff <= rtb_pkg::FireCntW'(rtb_pkg::MaxResults))
      else $error("drain pointer or count out of range");

   // An error result carries index zero and closes its item
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == rtb_pkg::KIND_ERROR |-> rsp_idx_ff == '0 && rsp_last_ff)
      else $error("malformed error result");

   // An accepted tick launches a token in the next cycle
   a_tick_launch: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == rtb_pkg::OP_TICK |=> tok0_ff.valid)
      else $error("tick accepted without launching a scan token");

endmodule

`default_nettype wire
